// ===== rtl/core/cbd_pkg.sv =====
`timescale 1ns / 1ps

package cbd_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned RGB_W      = 24;
  localparam int unsigned TOL_W      = 8;
  localparam int unsigned DIM_CFG_W  = 13;
  localparam int unsigned RES_W      = 13;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [BYTE_W-1:0] BG_ALPHA = 8'hff;

  localparam logic [RGB_W-1:0]     RST_BG_RGB = 24'hffffff;
  localparam logic [TOL_W-1:0]     RST_TOL    = 8'd0;
  localparam logic [DIM_CFG_W-1:0] RST_LIMIT  = 13'd0;
  localparam logic [DIM_CFG_W-1:0] RST_WIDTH  = 13'd4096;
  localparam logic [DIM_CFG_W-1:0] RST_HEIGHT = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BG_RGB = 3'd0,
    CFG_TOL    = 3'd1,
    CFG_LIMIT  = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4
  } cbd_cfg_idx_e;

  // Per-pixel classification handed from front to back.
  typedef struct packed {
    logic mismatch;
    logic first_row;
    logic row_end;
    logic last_row;
    logic row_hit;
  } cbd_flags_t;

endpackage

// ===== rtl/core/cbd_front.sv =====
`timescale 1ns / 1ps

module cbd_front #(
  parameter int unsigned MAX_WIDTH  = cbd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = cbd_pkg::DEF_MAX_HEIGHT,
  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pixel_valid_i,
  output logic                            pixel_ready_o,
  input  logic [cbd_pkg::PIXEL_W-1:0]     pixel_i,
  input  logic [cbd_pkg::RGB_W-1:0]       bg_rgb_i,
  input  logic [cbd_pkg::TOL_W-1:0]       tol_i,
  input  logic [cbd_pkg::DIM_CFG_W-1:0]   limit_i,
  input  logic [WW-1:0]                   width_i,
  input  logic [HW-1:0]                   height_i,
  input  logic                            push_ready_i,
  output logic                            push_valid_o,
  output cbd_pkg::cbd_flags_t             flags_o,
  output logic [XW-1:0]                   x_o,
  output logic [YW-1:0]                   y_o
);
  import cbd_pkg::*;

  localparam int unsigned RW = $clog2(MAX_WIDTH + 1);

  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [RW-1:0] row_count_q, row_count_d;

  logic [PIXEL_W-1:0] bg_word;
  logic               mismatch;
  logic               row_end;
  logic               last_row;
  logic [RW-1:0]      rc_base;
  logic [31:0]        rc_sum;
  logic               accept;

  assign bg_word = {BG_ALPHA, bg_rgb_i};

  always_comb begin
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] diff;
    mismatch = 1'b0;
    for (int i = 0; i < PIXEL_W / BYTE_W; i++) begin
      a    = pixel_i[i*BYTE_W +: BYTE_W];
      b    = bg_word[i*BYTE_W +: BYTE_W];
      diff = (a > b) ? (a - b) : (b - a);
      if (diff > tol_i) begin
        mismatch = 1'b1;
      end
    end
  end

  assign row_end  = 32'(x_q) >= (32'(width_i) - 32'd1);
  assign last_row = 32'(y_q) >= (32'(height_i) - 32'd1);

  assign rc_base = (x_q == '0) ? '0 : row_count_q;
  assign rc_sum  = 32'(rc_base) + 32'(mismatch);

  always_comb begin
    if (rc_sum <= 32'(MAX_WIDTH)) begin
      row_count_d = RW'(rc_sum);
    end else begin
      row_count_d = rc_base;
    end
  end

  assign pixel_ready_o = push_ready_i;
  assign push_valid_o  = pixel_valid_i;
  assign accept        = pixel_valid_i && push_ready_i;

  assign flags_o.mismatch  = mismatch;
  assign flags_o.first_row = (y_q == '0);
  assign flags_o.row_end   = row_end;
  assign flags_o.last_row  = last_row;
  assign flags_o.row_hit   = 32'(row_count_d) > 32'(limit_i);
  assign x_o = x_q;
  assign y_o = y_q;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (row_end) begin
      x_d = '0;
      y_d = last_row ? '0 : (y_q + YW'(1));
    end else begin
      x_d = x_q + XW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      row_count_q <= '0;
    end else if (accept) begin
      x_q         <= x_d;
      y_q         <= y_d;
      row_count_q <= row_count_d;
    end
  end

endmodule

// ===== rtl/core/cbd_fifo.sv =====
`timescale 1ns / 1ps

module cbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : (wr_ptr_q + PW'(1));
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : (rd_ptr_q + PW'(1));
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/cbd_back.sv =====
`timescale 1ns / 1ps

module cbd_back #(
  parameter int unsigned MAX_WIDTH  = cbd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = cbd_pkg::DEF_MAX_HEIGHT,
  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  output logic                          pop_o,
  input  cbd_pkg::cbd_flags_t           head_flags_i,
  input  logic [XW-1:0]                 head_x_i,
  input  logic [YW-1:0]                 head_y_i,
  input  logic [cbd_pkg::DIM_CFG_W-1:0] limit_i,
  input  logic [WW-1:0]                 width_i,
  input  logic [HW-1:0]                 height_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic [cbd_pkg::RES_W-1:0]     top_rows_o,
  output logic [cbd_pkg::RES_W-1:0]     bottom_rows_o,
  output logic [cbd_pkg::RES_W-1:0]     left_columns_o,
  output logic [cbd_pkg::RES_W-1:0]     right_columns_o
);
  import cbd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0] col_mem [MAX_WIDTH];

  // Execute stage: one pixel with its column counter read back.
  logic          ex_valid_q, ex_valid_d;
  cbd_flags_t    ex_flags_q;
  logic [XW-1:0] ex_x_q;
  logic [YW-1:0] ex_y_q;
  logic [CW-1:0] ex_rdata_q;
  logic          ex_fwd_q;
  logic [CW-1:0] ex_fwd_val_q;

  logic          row_found_q, row_found_d;
  logic [YW-1:0] first_row_q, first_row_d;
  logic [YW-1:0] last_row_q, last_row_d;
  logic          col_found_q, col_found_d;
  logic [XW-1:0] first_col_q, first_col_d;
  logic [XW-1:0] last_col_q, last_col_d;

  logic          out_valid_q, out_valid_d;
  logic [RES_W-1:0] top_q, bottom_q, left_q, right_q;
  logic [RES_W-1:0] top_d, bottom_d, left_d, right_d;

  logic          frame_end;
  logic          fire;
  logic          load_ex;
  logic [CW-1:0] col_old;
  logic [31:0]   col_sum;
  logic [CW-1:0] col_new;
  logic          col_hit;
  logic          row_hit;

  assign frame_end = ex_flags_q.row_end && ex_flags_q.last_row;
  assign fire      = ex_valid_q && (!frame_end || !out_valid_q || result_ready_i);
  assign load_ex   = head_valid_i && (!ex_valid_q || fire);
  assign pop_o     = load_ex;

  always_comb begin
    if (ex_flags_q.first_row) begin
      col_old = '0;
    end else if (ex_fwd_q) begin
      col_old = ex_fwd_val_q;
    end else begin
      col_old = ex_rdata_q;
    end
  end

  assign col_sum = 32'(col_old) + 32'(ex_flags_q.mismatch);
  assign col_new = (col_sum <= 32'(MAX_HEIGHT)) ? CW'(col_sum) : col_old;
  assign col_hit = ex_flags_q.last_row && (32'(col_new) > 32'(limit_i));
  assign row_hit = ex_flags_q.row_end && ex_flags_q.row_hit;

  always_comb begin
    row_found_d = row_found_q || row_hit;
    first_row_d = (row_hit && !row_found_q) ? ex_y_q : first_row_q;
    last_row_d  = row_hit ? ex_y_q : last_row_q;
    col_found_d = col_found_q || col_hit;
    first_col_d = (col_hit && !col_found_q) ? ex_x_q : first_col_q;
    last_col_d  = col_hit ? ex_x_q : last_col_q;
  end

  always_comb begin
    top_d    = row_found_d ? RES_W'(first_row_d) : RES_W'(height_i);
    left_d   = col_found_d ? RES_W'(first_col_d) : RES_W'(width_i);
    bottom_d = '0;
    right_d  = '0;
    if (row_found_d && (32'(last_row_d) < 32'(height_i))) begin
      bottom_d = RES_W'(32'(height_i) - 32'd1 - 32'(last_row_d));
    end
    if (col_found_d && (32'(last_col_d) < 32'(width_i))) begin
      right_d = RES_W'(32'(width_i) - 32'd1 - 32'(last_col_d));
    end
  end

  always_comb begin
    ex_valid_d = ex_valid_q;
    if (load_ex) begin
      ex_valid_d = 1'b1;
    end else if (fire) begin
      ex_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire && frame_end) begin
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      row_found_q <= 1'b0;
      first_row_q <= '0;
      last_row_q  <= '0;
      col_found_q <= 1'b0;
      first_col_q <= '0;
      last_col_q  <= '0;
    end else begin
      ex_valid_q  <= ex_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        if (frame_end) begin
          // Restart tracking for the next frame.
          row_found_q <= 1'b0;
          first_row_q <= '0;
          last_row_q  <= '0;
          col_found_q <= 1'b0;
          first_col_q <= '0;
          last_col_q  <= '0;
        end else begin
          row_found_q <= row_found_d;
          first_row_q <= first_row_d;
          last_row_q  <= last_row_d;
          col_found_q <= col_found_d;
          first_col_q <= first_col_d;
          last_col_q  <= last_col_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      col_mem[ex_x_q] <= col_new;
    end
    if (load_ex) begin
      ex_flags_q   <= head_flags_i;
      ex_x_q       <= head_x_i;
      ex_y_q       <= head_y_i;
      ex_rdata_q   <= col_mem[head_x_i];
      // Bypass the counter being written this cycle to the same column.
      ex_fwd_q     <= fire && (ex_x_q == head_x_i);
      ex_fwd_val_q <= col_new;
    end
    if (fire && frame_end) begin
      top_q    <= top_d;
      bottom_q <= bottom_d;
      left_q   <= left_d;
      right_q  <= right_d;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign top_rows_o      = top_q;
  assign bottom_rows_o   = bottom_q;
  assign left_columns_o  = left_q;
  assign right_columns_o = right_q;

endmodule

// ===== rtl/core/content_border_detector_top.sv =====
`timescale 1ns / 1ps

// Content border detector: measures the empty border of a raster frame.
//
// Pixel channel: one 32-bit ARGB word per beat, raster order, on
// pixel_valid_i / pixel_ready_o. Result channel: one beat per frame on
// result_valid_o / result_ready_i, carrying the empty row counts at top and
// bottom and the empty column counts at left and right.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 background RGB, 1 tolerance, 2 mismatch limit, 3 width, 4 height).
// Write it only with no pixels in flight.
//
// Throughput: one pixel per cycle while the receiver takes results. That rate is set by the per-column
// mismatch counter, a read-modify-write on a single memory of MAX_WIDTH
// entries with a one-entry bypass. The result of a frame is registered once
// its last pixel has passed through the queue and the execute stage.
// Reset clears positions, row and column tracking and loads the register
// defaults; the column memory needs no clearing since the first row of each
// frame overwrites it. If the receiver stalls, the result waits in the
// output register, pixels keep flowing into the back end until the next
// frame end, then a four-entry queue fills and pixel_ready_o drops.
module content_border_detector_top #(
  parameter int unsigned MAX_WIDTH  = cbd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = cbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cbd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cbd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           pixel_valid_i,
  output logic                           pixel_ready_o,
  input  logic [cbd_pkg::PIXEL_W-1:0]    pixel_i,
  output logic                           result_valid_o,
  input  logic                           result_ready_i,
  output logic [cbd_pkg::RES_W-1:0]      top_rows_o,
  output logic [cbd_pkg::RES_W-1:0]      bottom_rows_o,
  output logic [cbd_pkg::RES_W-1:0]      left_columns_o,
  output logic [cbd_pkg::RES_W-1:0]      right_columns_o
);
  import cbd_pkg::*;

  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned FLAGS_W = $bits(cbd_flags_t);
  localparam int unsigned QW = FLAGS_W + XW + YW;

  logic [RGB_W-1:0]     bg_rgb_q;
  logic [TOL_W-1:0]     tol_q;
  logic [DIM_CFG_W-1:0] limit_q;
  logic [DIM_CFG_W-1:0] width_q;
  logic [DIM_CFG_W-1:0] height_q;

  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;

  logic          push_valid;
  logic          push_ready;
  cbd_flags_t    push_flags;
  logic [XW-1:0] push_x;
  logic [YW-1:0] push_y;
  logic          head_valid;
  logic          pop;
  logic [QW-1:0] head_data;
  cbd_flags_t    head_flags;
  logic [XW-1:0] head_x;
  logic [YW-1:0] head_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_rgb_q <= RST_BG_RGB;
      tol_q    <= RST_TOL;
      limit_q  <= RST_LIMIT;
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      case (cbd_cfg_idx_e'(cfg_index_i))
        CFG_BG_RGB: bg_rgb_q <= cfg_data_i[RGB_W-1:0];
        CFG_TOL:    tol_q    <= cfg_data_i[TOL_W-1:0];
        CFG_LIMIT:  limit_q  <= cfg_data_i[DIM_CFG_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[DIM_CFG_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DIM_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Zero acts as one, oversize clamps to the maximum.
  always_comb begin
    if (width_q == '0) begin
      width_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      height_eff = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(height_q);
    end
  end

  cbd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pixel_valid_i(pixel_valid_i),
    .pixel_ready_o(pixel_ready_o),
    .pixel_i      (pixel_i),
    .bg_rgb_i     (bg_rgb_q),
    .tol_i        (tol_q),
    .limit_i      (limit_q),
    .width_i      (width_eff),
    .height_i     (height_eff),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .flags_o      (push_flags),
    .x_o          (push_x),
    .y_o          (push_y)
  );

  cbd_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_flags, push_x, push_y}),
    .pop_valid_o (head_valid),
    .pop_i       (pop),
    .pop_data_o  (head_data)
  );

  assign head_flags = cbd_flags_t'(head_data[QW-1 -: FLAGS_W]);
  assign head_x     = head_data[YW +: XW];
  assign head_y     = head_data[YW-1:0];

  cbd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .head_flags_i   (head_flags),
    .head_x_i       (head_x),
    .head_y_i       (head_y),
    .limit_i        (limit_q),
    .width_i        (width_eff),
    .height_i       (height_eff),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .top_rows_o     (top_rows_o),
    .bottom_rows_o  (bottom_rows_o),
    .left_columns_o (left_columns_o),
    .right_columns_o(right_columns_o)
  );

endmodule
